/* hw/rtl/stack_sequence_checker_assert.svh */
// Assertion macros used by the checker file of the stack sequence checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STACK_SEQUENCE_CHECKER_ASSERT_SVH
`define STACK_SEQUENCE_CHECKER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define SSC_ASSERT_NOW(label, cond, expect_now) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error("stack sequence checker: same-cycle rule broken");

// Next-cycle implication, switched off while reset is high.
`define SSC_ASSERT_NEXT(label, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error("stack sequence checker: next-cycle rule broken");

`endif

/* hw/rtl/ssc_pkg.sv */
// Package of the stack sequence checker: word types, sizing constants and
// the sequencer state type. Depends on nothing.
`default_nettype none

package ssc_pkg;

  localparam int SSC_MAX_SHIPS  = 16;
  localparam int SSC_IDENT_BITS = 4;

  typedef struct packed {
    logic                      action;
    logic [SSC_IDENT_BITS-1:0] ident;
    logic                      final_entry;
  } ssc_item_t;

  typedef struct packed {
    logic feasible;
    logic move;
    logic run_end;
  } ssc_result_t;

  // Input word kinds.
  localparam logic ACT_ARRIVAL   = 1'b0;
  localparam logic ACT_DEPARTURE = 1'b1;

  // Move codes in the result word.
  localparam logic MOVE_PUSH = 1'b0;
  localparam logic MOVE_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_PUSH,
    ST_POP,
    ST_FETCH,
    ST_SEND,
    ST_FAIL
  } ssc_state_t;

endpackage

`default_nettype wire

/* hw/rtl/stack_sequence_checker.sv */
// Top level of the stack sequence checker: list stores, LIFO simulation
// sequencer and move log. Depends on ssc_pkg.
`default_nettype none

// The block takes one word per cycle while loading the arrival and departure
// lists. The departure word marked final starts the check. ST_START tests
// the lengths and overflow. Then each push is one ST_PUSH step, each pop is
// one ST_POP step, and one more ST_POP step follows each push's pops where
// the compare finds no further match. The pops rest on the single compare
// between the stack top and the next wanted departure. A feasible run of n
// ships then sends each of its 2n moves by a read of the move log's read
// port (ST_FETCH) and an offer of the word held while result_stall is high
// (ST_SEND), and a failed run sends one word. Input stall is high from the
// final departure word until the last result word of the run is taken.
module stack_sequence_checker #(
  parameter int MAX_SHIPS = ssc_pkg::SSC_MAX_SHIPS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output      logic                item_stall,
  input  wire ssc_pkg::ssc_item_t   item,
  output      logic                result_valid,
  input  wire logic                result_stall,
  output      ssc_pkg::ssc_result_t result
);

  import ssc_pkg::*;

  localparam int CNT_W = $clog2(MAX_SHIPS + 1);
  localparam int IDX_W = (MAX_SHIPS > 1) ? $clog2(MAX_SHIPS) : 1;
  localparam int MV_W  = $clog2(2 * MAX_SHIPS + 1);
  localparam int LOG_W = $clog2(2 * MAX_SHIPS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SHIPS);

  logic [SSC_IDENT_BITS-1:0] arrival_store   [MAX_SHIPS];
  logic [SSC_IDENT_BITS-1:0] departure_store [MAX_SHIPS];
  logic [SSC_IDENT_BITS-1:0] lifo_store      [MAX_SHIPS];
  logic                      move_log        [2 * MAX_SHIPS];

  ssc_state_t       state, state_next;
  logic [CNT_W-1:0] arrival_count, arrival_count_next;
  logic [CNT_W-1:0] departure_count, departure_count_next;
  logic [CNT_W-1:0] lifo_depth, lifo_depth_next;
  logic             overflow_flag, overflow_flag_next;
  logic [CNT_W-1:0] push_idx, push_idx_next;
  logic [CNT_W-1:0] want, want_next;
  logic [MV_W-1:0]  moves, moves_next;
  logic [MV_W-1:0]  emit_idx, emit_idx_next;
  logic             log_q;

  logic arrival_we, departure_we, lifo_we, log_we, log_bit, log_rd_en;
  logic top_match, last_move;
  logic [SSC_IDENT_BITS-1:0] lifo_top, wanted_ident;

  // The single compare: top of the stack against the next wanted departure.
  assign lifo_top     = lifo_store[IDX_W'(lifo_depth - CNT_W'(1))];
  assign wanted_ident = departure_store[want[IDX_W-1:0]];
  assign top_match    = (lifo_top == wanted_ident);
  assign last_move    = (MV_W'(emit_idx + MV_W'(1)) == moves);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_LOAD;
      arrival_count   <= '0;
      departure_count <= '0;
      lifo_depth      <= '0;
      overflow_flag   <= 1'b0;
      push_idx        <= '0;
      want            <= '0;
      moves           <= '0;
      emit_idx        <= '0;
    end else begin
      state           <= state_next;
      arrival_count   <= arrival_count_next;
      departure_count <= departure_count_next;
      lifo_depth      <= lifo_depth_next;
      overflow_flag   <= overflow_flag_next;
      push_idx        <= push_idx_next;
      want            <= want_next;
      moves           <= moves_next;
      emit_idx        <= emit_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (arrival_we) begin
      arrival_store[arrival_count[IDX_W-1:0]] <= item.ident;
    end
    if (departure_we) begin
      departure_store[departure_count[IDX_W-1:0]] <= item.ident;
    end
    if (lifo_we) begin
      lifo_store[lifo_depth[IDX_W-1:0]] <= arrival_store[push_idx[IDX_W-1:0]];
    end
  end

  // Move log: one write port for the check, one registered read for sending.
  always_ff @(posedge clk) begin
    if (log_we) begin
      move_log[moves[LOG_W-1:0]] <= log_bit;
    end
    if (log_rd_en) begin
      log_q <= move_log[emit_idx[LOG_W-1:0]];
    end
  end

  always_comb begin
    state_next           = state;
    arrival_count_next   = arrival_count;
    departure_count_next = departure_count;
    lifo_depth_next      = lifo_depth;
    overflow_flag_next   = overflow_flag;
    push_idx_next        = push_idx;
    want_next            = want;
    moves_next           = moves;
    emit_idx_next        = emit_idx;
    arrival_we           = 1'b0;
    departure_we         = 1'b0;
    lifo_we              = 1'b0;
    log_we               = 1'b0;
    log_bit              = MOVE_PUSH;
    log_rd_en            = 1'b0;
    item_stall           = 1'b1;
    result_valid         = 1'b0;
    result               = '0;

    unique case (state)
      ST_LOAD: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (item.action == ACT_ARRIVAL) begin
            if (arrival_count < MAX_CNT) begin
              arrival_we         = 1'b1;
              arrival_count_next = arrival_count + CNT_W'(1);
            end else begin
              overflow_flag_next = 1'b1;
            end
          end else begin
            if (departure_count < MAX_CNT) begin
              departure_we         = 1'b1;
              departure_count_next = departure_count + CNT_W'(1);
            end else begin
              overflow_flag_next = 1'b1;
            end
            if (item.final_entry) begin
              state_next = ST_START;
            end
          end
        end
      end

      ST_START: begin
        if (!overflow_flag && (arrival_count == departure_count) &&
            (arrival_count != '0)) begin
          push_idx_next   = '0;
          want_next       = '0;
          lifo_depth_next = '0;
          moves_next      = '0;
          state_next      = ST_PUSH;
        end else begin
          state_next = ST_FAIL;
        end
      end

      ST_PUSH: begin
        lifo_we         = 1'b1;
        lifo_depth_next = lifo_depth + CNT_W'(1);
        log_we          = 1'b1;
        log_bit         = MOVE_PUSH;
        moves_next      = moves + MV_W'(1);
        push_idx_next   = push_idx + CNT_W'(1);
        state_next      = ST_POP;
      end

      ST_POP: begin
        if ((lifo_depth != '0) && (want < arrival_count) && top_match) begin
          lifo_depth_next = lifo_depth - CNT_W'(1);
          want_next       = want + CNT_W'(1);
          log_we          = 1'b1;
          log_bit         = MOVE_POP;
          moves_next      = moves + MV_W'(1);
        end else if (push_idx < arrival_count) begin
          state_next = ST_PUSH;
        end else if (lifo_depth == '0) begin
          emit_idx_next = '0;
          state_next    = ST_FETCH;
        end else begin
          state_next = ST_FAIL;
        end
      end

      ST_FETCH: begin
        log_rd_en  = 1'b1;
        state_next = ST_SEND;
      end

      ST_SEND: begin
        result_valid     = 1'b1;
        result.feasible  = 1'b1;
        result.move      = log_q;
        result.run_end   = last_move;
        if (!result_stall) begin
          if (last_move) begin
            arrival_count_next   = '0;
            departure_count_next = '0;
            lifo_depth_next      = '0;
            overflow_flag_next   = 1'b0;
            state_next           = ST_LOAD;
          end else begin
            emit_idx_next = emit_idx + MV_W'(1);
            state_next    = ST_FETCH;
          end
        end
      end

      ST_FAIL: begin
        result_valid    = 1'b1;
        result.feasible = 1'b0;
        result.move     = MOVE_PUSH;
        result.run_end  = 1'b1;
        if (!result_stall) begin
          arrival_count_next   = '0;
          departure_count_next = '0;
          lifo_depth_next      = '0;
          overflow_flag_next   = 1'b0;
          state_next           = ST_LOAD;
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ssc_checker.sv */
// Port checker of the stack sequence checker, attached by the bind below.
// Depends on ssc_pkg and stack_sequence_checker_assert.svh.
`default_nettype none

`include "stack_sequence_checker_assert.svh"

module ssc_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 item_valid,
  input wire logic                 item_stall,
  input wire ssc_pkg::ssc_item_t   item,
  input wire logic                 result_valid,
  input wire logic                 result_stall,
  input wire ssc_pkg::ssc_result_t result
);

  import ssc_pkg::*;

  // No new word is taken while a result word is on offer.
  `SSC_ASSERT_NOW(a_busy_while_sending, result_valid, item_stall)

  // A failure report is a single word that closes the run.
  `SSC_ASSERT_NOW(a_fail_word, result_valid && !result.feasible,
                  result.run_end && (result.move == MOVE_PUSH))

  // The final departure word starts the check, so input stalls next cycle.
  `SSC_ASSERT_NEXT(a_check_starts, item_valid && !item_stall &&
                   (item.action == ACT_DEPARTURE) && item.final_entry, item_stall)

  // Once the last word of a run is taken, loading resumes at once.
  `SSC_ASSERT_NEXT(a_reload_after_run, result_valid && !result_stall && result.run_end,
                   !item_stall && !result_valid)

  // A stalled result word stays on offer unchanged.
  `SSC_ASSERT_NEXT(a_result_holds, result_valid && result_stall,
                   result_valid && $stable(result))

endmodule

bind stack_sequence_checker ssc_checker u_ssc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
